// ===== hw/rtl/bcf_pkg.sv =====
// Shared definitions for the Bezier curve flattener: default sizes and the
// command/status structs between the controller and the datapath.
// No dependencies.
package bcf_pkg;

  localparam int MAX_SEGMENTS_DEF = 63;
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int T_FRAC_BITS_DEF  = 16;
  localparam int SEG_WIDTH        = 6;

  // Accumulator operation for one cycle of the point evaluation
  typedef enum logic [2:0] {
    MAC_IDLE,
    MAC_LOAD,   // acc = start point at the top weight
    MAC_CT,     // acc += c * t
    MAC_B0,     // acc += b * t^2, low chunk
    MAC_B1,     // acc += b * t^2, high chunk
    MAC_A0,     // acc += a * t^3, chunks low to high
    MAC_A1,
    MAC_A2
  } mac_op_t;

  typedef struct packed {
    logic    capture;
    logic    div_step;
    logic    t_advance;
    logic    t2_en;
    logic    t3_en;
    mac_op_t mac_op;
    logic    out_load_pt;
    logic    out_load_end;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_seg;
    logic cubic;
  } sts_t;

endpackage

// ===== hw/rtl/bcf_datapath.sv =====
// Datapath of the Bezier curve flattener: curve coefficients, the serial
// divider for 1/N, the parameter stepper and the two multiply-accumulate lanes.
// Depends on bcf_pkg.
module bcf_datapath #(
  parameter int MAX_SEGMENTS = bcf_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH  = bcf_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS  = bcf_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  bcf_pkg::cmd_t                 cmd,
  output bcf_pkg::sts_t                 sts,
  input  logic                          func,
  input  logic [COORD_WIDTH-1:0]        start_x,
  input  logic [COORD_WIDTH-1:0]        start_y,
  input  logic [COORD_WIDTH-1:0]        ctrl_a_x,
  input  logic [COORD_WIDTH-1:0]        ctrl_a_y,
  input  logic [COORD_WIDTH-1:0]        ctrl_b_x,
  input  logic [COORD_WIDTH-1:0]        ctrl_b_y,
  input  logic [COORD_WIDTH-1:0]        end_x,
  input  logic [COORD_WIDTH-1:0]        end_y,
  input  logic [bcf_pkg::SEG_WIDTH-1:0] segments,
  output logic [COORD_WIDTH-1:0]        point_x,
  output logic [COORD_WIDTH-1:0]        point_y
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = T_FRAC_BITS;
  localparam int NW = bcf_pkg::SEG_WIDTH;
  localparam int CC = CW + 4;          // polynomial coefficient width (3*(p0-2p1+p2))
  localparam int PW = CC + F + 1;      // coefficient times one chunk of t
  localparam int AW = CW + 3 * F;      // accumulator, kept modulo 2^AW
  localparam int DW = $clog2(F + 1);
  localparam logic [AW-1:0] RND_HALF = AW'(1) << (3 * F - 1);

  typedef struct packed {
    logic signed [CC-1:0] a;
    logic signed [CC-1:0] b;
    logic signed [CC-1:0] c;
  } coef_t;

  // Power basis: S = a*t^3 + b*t^2*ONE + c*t*ONE^2 + p0*ONE^3.
  // A quadratic is the same form with a = 0.
  function automatic coef_t make_coef(input logic cub, input logic [CW-1:0] s0,
                                      input logic [CW-1:0] s1, input logic [CW-1:0] s2,
                                      input logic [CW-1:0] s3);
    logic signed [CC-1:0] p0, p1, p2, p3, d10, d12, mid;
    coef_t r;
    p0  = {{(CC-CW){s0[CW-1]}}, s0};
    p1  = {{(CC-CW){s1[CW-1]}}, s1};
    p2  = {{(CC-CW){s2[CW-1]}}, s2};
    p3  = {{(CC-CW){s3[CW-1]}}, s3};
    d10 = p1 - p0;
    d12 = p1 - p2;
    if (cub) begin
      mid = p0 - (p1 <<< 1) + p2;
      r.c = (d10 <<< 1) + d10;
      r.b = (mid <<< 1) + mid;
      r.a = p3 - p0 + (d12 <<< 1) + d12;
    end else begin
      r.c = d10 <<< 1;
      r.b = p0 - (p1 <<< 1) + p3;
      r.a = '0;
    end
    return r;
  endfunction

  logic [CW-1:0] in_p0 [2];
  logic [CW-1:0] in_p1 [2];
  logic [CW-1:0] in_p2 [2];
  logic [CW-1:0] in_p3 [2];

  assign in_p0[0] = start_x;   assign in_p0[1] = start_y;
  assign in_p1[0] = ctrl_a_x;  assign in_p1[1] = ctrl_a_y;
  assign in_p2[0] = ctrl_b_x;  assign in_p2[1] = ctrl_b_y;
  assign in_p3[0] = end_x;     assign in_p3[1] = end_y;

  // item registers
  logic          cubic;
  logic [NW-1:0] n;
  logic [CW-1:0] start_r [2];
  logic [CW-1:0] end_r   [2];
  coef_t         coef    [2];

  // divider, stepper, point counter
  logic [DW-1:0] dcnt;
  logic [NW-1:0] drem;
  logic [F:0]    dquo;
  logic [F:0]    tq;
  logic [NW:0]   tr;
  logic [NW-1:0] pcnt;

  // powers of t and accumulators
  logic [2*F-1:0] t2;
  logic [3*F-1:0] t3;
  logic [AW-1:0]  acc [2];

  logic [NW-1:0]  n_in;
  logic [NW:0]    rem_s;
  logic           qbit;
  logic [NW-1:0]  drem_next;
  logic [NW+1:0]  tr_sum;
  logic [NW+1:0]  tr_diff;
  logic [NW+1:0]  two_n;
  logic [F:0]     tq_next;
  logic [NW:0]    tr_next;
  logic [F-1:0]   t;
  logic [2*F-1:0] tmul_a;
  logic [3*F-1:0] tmul;
  logic [F-1:0]   chunk;
  logic [1:0]     pos;
  logic signed [CC-1:0] coef_sel [2];
  logic signed [PW-1:0] prod     [2];
  logic [AW-1:0]  prod_ext [2];
  logic [AW-1:0]  prod_sh  [2];
  logic [AW-1:0]  acc_next [2];
  logic [AW-1:0]  rnd      [2];

  // zero segments act as one, too many are clamped
  always_comb begin
    if (segments == '0) begin
      n_in = NW'(1);
    end else if (segments > NW'(MAX_SEGMENTS)) begin
      n_in = NW'(MAX_SEGMENTS);
    end else begin
      n_in = segments;
    end
  end

  // restoring division of 2^F by N, one quotient bit a cycle
  always_comb begin
    qbit      = 1'b0;
    rem_s     = {drem, (dcnt == '0)};
    drem_next = rem_s[NW-1:0];
    if (rem_s >= {1'b0, n}) begin
      qbit      = 1'b1;
      drem_next = NW'(rem_s - {1'b0, n});
    end
  end

  // t = round(i*ONE/N) kept as quotient tq and remainder tr against 2N
  always_comb begin
    two_n   = {1'b0, n, 1'b0};
    tr_sum  = {1'b0, tr} + {1'b0, drem, 1'b0};
    tr_diff = tr_sum - two_n;
    tq_next = tq + dquo;
    tr_next = tr_sum[NW:0];
    if (tr_sum >= two_n) begin
      tq_next = tq + dquo + (F+1)'(1);
      tr_next = tr_diff[NW:0];
    end
  end

  assign t      = tq[F-1:0];
  assign tmul_a = cmd.t3_en ? t2 : {{F{1'b0}}, t};
  assign tmul   = tmul_a * t;

  // multiply-accumulate, one chunk of a power of t per cycle
  always_comb begin
    chunk = t;
    pos   = 2'd2;
    for (int l = 0; l < 2; l++) begin
      coef_sel[l] = coef[l].c;
    end
    unique case (cmd.mac_op)
      bcf_pkg::MAC_B0: begin
        chunk = t2[F-1:0];
        pos   = 2'd1;
        for (int l = 0; l < 2; l++) coef_sel[l] = coef[l].b;
      end
      bcf_pkg::MAC_B1: begin
        chunk = t2[2*F-1:F];
        pos   = 2'd2;
        for (int l = 0; l < 2; l++) coef_sel[l] = coef[l].b;
      end
      bcf_pkg::MAC_A0: begin
        chunk = t3[F-1:0];
        pos   = 2'd0;
        for (int l = 0; l < 2; l++) coef_sel[l] = coef[l].a;
      end
      bcf_pkg::MAC_A1: begin
        chunk = t3[2*F-1:F];
        pos   = 2'd1;
        for (int l = 0; l < 2; l++) coef_sel[l] = coef[l].a;
      end
      bcf_pkg::MAC_A2: begin
        chunk = t3[3*F-1:2*F];
        pos   = 2'd2;
        for (int l = 0; l < 2; l++) coef_sel[l] = coef[l].a;
      end
      default: begin
      end
    endcase

    for (int l = 0; l < 2; l++) begin
      prod[l]     = coef_sel[l] * $signed({1'b0, chunk});
      prod_ext[l] = {{(AW-PW){prod[l][PW-1]}}, prod[l]};
      case (pos)
        2'd0:    prod_sh[l] = prod_ext[l];
        2'd1:    prod_sh[l] = prod_ext[l] << F;
        default: prod_sh[l] = prod_ext[l] << (2 * F);
      endcase
      unique case (cmd.mac_op)
        bcf_pkg::MAC_IDLE: acc_next[l] = acc[l];
        bcf_pkg::MAC_LOAD: acc_next[l] = {start_r[l], {(3*F){1'b0}}};
        default:           acc_next[l] = acc[l] + prod_sh[l];
      endcase
      rnd[l] = acc[l] + RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cubic <= func;
      n     <= n_in;
      dcnt  <= '0;
      drem  <= '0;
      dquo  <= '0;
      tq    <= '0;
      tr    <= {1'b0, n_in};
      pcnt  <= '0;
      for (int l = 0; l < 2; l++) begin
        start_r[l] <= in_p0[l];
        end_r[l]   <= in_p3[l];
        coef[l]    <= make_coef(func, in_p0[l], in_p1[l], in_p2[l], in_p3[l]);
      end
    end
    if (cmd.div_step) begin
      dcnt <= dcnt + DW'(1);
      drem <= drem_next;
      dquo <= {dquo[F-1:0], qbit};
    end
    if (cmd.t_advance) begin
      tq   <= tq_next;
      tr   <= tr_next;
      pcnt <= pcnt + NW'(1);
    end
    if (cmd.t2_en) begin
      t2 <= tmul[2*F-1:0];
    end
    if (cmd.t3_en) begin
      t3 <= tmul;
    end
    for (int l = 0; l < 2; l++) begin
      acc[l] <= acc_next[l];
    end
    if (cmd.out_load_pt) begin
      point_x <= rnd[0][AW-1:3*F];
      point_y <= rnd[1][AW-1:3*F];
    end else if (cmd.out_load_end) begin
      point_x <= end_r[0];
      point_y <= end_r[1];
    end
  end

  assign sts.div_done = (dcnt == DW'(F));
  assign sts.last_seg = (pcnt == n - NW'(1));
  assign sts.cubic    = cubic;

endmodule

// ===== hw/rtl/bcf_ctrl.sv =====
// Controller of the Bezier curve flattener: sequences divide, per-point
// evaluation and output loads; owns the output valid and last flags.
// Depends on bcf_pkg.
module bcf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          last,
  input  bcf_pkg::sts_t sts,
  output bcf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_T2,
    ST_T3,
    ST_B0,
    ST_B1,
    ST_A0,
    ST_A1,
    ST_A2,
    ST_RND,
    ST_END
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mac_op = bcf_pkg::MAC_IDLE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = ST_T2;
      end
      ST_T2: begin
        cmd.mac_op = bcf_pkg::MAC_LOAD;
        cmd.t2_en  = 1'b1;
        state_next = ST_T3;
      end
      ST_T3: begin
        cmd.mac_op = bcf_pkg::MAC_CT;
        cmd.t3_en  = 1'b1;
        state_next = ST_B0;
      end
      ST_B0: begin
        cmd.mac_op = bcf_pkg::MAC_B0;
        state_next = ST_B1;
      end
      ST_B1: begin
        cmd.mac_op = bcf_pkg::MAC_B1;
        state_next = sts.cubic ? ST_A0 : ST_RND;
      end
      ST_A0: begin
        cmd.mac_op = bcf_pkg::MAC_A0;
        state_next = ST_A1;
      end
      ST_A1: begin
        cmd.mac_op = bcf_pkg::MAC_A1;
        state_next = ST_A2;
      end
      ST_A2: begin
        cmd.mac_op = bcf_pkg::MAC_A2;
        state_next = ST_RND;
      end
      ST_RND: begin
        if (out_free) begin
          cmd.out_load_pt = 1'b1;
          cmd.t_advance   = 1'b1;
          state_next      = sts.last_seg ? ST_END : ST_T2;
        end
      end
      ST_END: begin
        if (out_free) begin
          cmd.out_load_end = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load_pt || cmd.out_load_end) begin
        out_valid <= 1'b1;
        last      <= cmd.out_load_end;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/bezier_curve_flattener.sv =====
// Bezier curve flattener, top level: controller plus datapath.
// Depends on bcf_pkg, bcf_ctrl, bcf_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one quadratic (func=0) or cubic
//   (func=1) curve and a segment count N per transfer. Zero segments count as
//   one; counts above MAX_SEGMENTS are clamped. in_stall is high from the
//   cycle after a transfer until the curve's end point has been loaded into
//   the output register, so the block works on one curve at a time.
//   Output channel (out_valid/out_stall) gives N+1 points per curve: points
//   at t = round(i*2^T_FRAC_BITS/N)/2^T_FRAC_BITS for i = 0..N-1, rounded
//   to nearest (ties up), then the end point itself with last = 1.
// Sequence:
//   setup runs the serial divider for 1/N, one quotient bit per cycle;
//   then each point steps through ST_T2, ST_T3, ST_B0, ST_B1 (plus ST_A0,
//   ST_A1 and ST_A2 for a cubic) and ST_RND, one shared multiply-accumulate
//   step per cycle with x and y in parallel, ST_RND waiting while the output
//   register is full. The end point is loaded last, in ST_END.
// Stall: the output register holds its point while out_stall is high; the
//   evaluation of the next point waits for the register to free up.
// Reset: rst (synchronous) returns the controller to idle and drops
//   out_valid; the datapath holds no state that reset needs to clear.
module bezier_curve_flattener #(
  parameter int MAX_SEGMENTS = bcf_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH  = bcf_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS  = bcf_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [COORD_WIDTH-1:0]        start_x,
  input  logic [COORD_WIDTH-1:0]        start_y,
  input  logic [COORD_WIDTH-1:0]        ctrl_a_x,
  input  logic [COORD_WIDTH-1:0]        ctrl_a_y,
  input  logic [COORD_WIDTH-1:0]        ctrl_b_x,
  input  logic [COORD_WIDTH-1:0]        ctrl_b_y,
  input  logic [COORD_WIDTH-1:0]        end_x,
  input  logic [COORD_WIDTH-1:0]        end_y,
  input  logic [bcf_pkg::SEG_WIDTH-1:0] segments,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_WIDTH-1:0]        point_x,
  output logic [COORD_WIDTH-1:0]        point_y,
  output logic                          last
);

  // command and status between the sequencer and the arithmetic
  bcf_pkg::cmd_t cmd;
  bcf_pkg::sts_t sts;

  bcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .sts       (sts),
    .cmd       (cmd)
  );

  // coefficients are formed at the input transfer; x and y lanes share t
  bcf_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_WIDTH  (COORD_WIDTH),
    .T_FRAC_BITS  (T_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .func     (func),
    .start_x  (start_x),
    .start_y  (start_y),
    .ctrl_a_x (ctrl_a_x),
    .ctrl_a_y (ctrl_a_y),
    .ctrl_b_x (ctrl_b_x),
    .ctrl_b_y (ctrl_b_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .segments (segments),
    .point_x  (point_x),
    .point_y  (point_y)
  );

endmodule

// ===== hw/rtl/bcf_checker.sv =====
// Port-level checks for the Bezier curve flattener, bound to the top level.
// Depends on bezier_curve_flattener.
module bcf_checker #(
  parameter int COORD_WIDTH = bcf_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COORD_WIDTH-1:0] point_x,
  input logic [COORD_WIDTH-1:0] point_y,
  input logic                   last
);

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
                               && $stable(last))
    else $error("stalled output point changed");

  // one curve at a time: a transfer makes the input busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // the input frees up only once the end point is presented
  a_free_on_end: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid && last)
    else $error("input freed before the end point");

  // while idle, a pending point can only be an end point
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_stall |-> last)
    else $error("non-final point pending while idle");

endmodule

bind bezier_curve_flattener bcf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_bcf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .point_x   (point_x),
  .point_y   (point_y),
  .last      (last)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for bezier_curve_flattener: random and corner curves, point-by-point
// checking against a bit-exact Bernstein predictor. Depends on bcf_pkg and the RTL.
module tb;

  localparam int CW     = bcf_pkg::COORD_WIDTH_DEF;
  localparam int TF     = bcf_pkg::T_FRAC_BITS_DEF;
  localparam int MAXSEG = bcf_pkg::MAX_SEGMENTS_DEF;
  localparam int SEGW   = bcf_pkg::SEG_WIDTH;

  localparam longint T_ONE = longint'(1) << TF;

  // curve degree on the func port
  localparam bit FUNC_QUAD  = 1'b0;
  localparam bit FUNC_CUBIC = 1'b1;

  localparam logic [CW-1:0] MAX_COORD = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_COORD = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ODD_BITS  = {(CW/2){2'b01}};
  localparam logic [CW-1:0] EVEN_BITS = {(CW/2){2'b10}};

  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 40;    // settle time after the last point

  typedef struct {
    bit              func;
    logic [CW-1:0]   sx, sy, ax, ay, bx, by, ex, ey;
    logic [SEGW-1:0] segs;
  } curve_t;

  typedef struct {
    logic [CW-1:0] x, y;
    logic          last;
  } point_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  logic            func;
  logic [CW-1:0]   start_x, start_y, ctrl_a_x, ctrl_a_y;
  logic [CW-1:0]   ctrl_b_x, ctrl_b_y, end_x, end_y;
  logic [SEGW-1:0] segments;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CW-1:0]   point_x, point_y;
  logic            last;

  // Expected points, oldest first
  point_t pending_points[$];

  int mismatches   = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;

  // Long hold-off: a test bumps hold_reqs, the stall process counts it out
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  bezier_curve_flattener u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact Bernstein sum in 96-bit signed, then round half up
  // ---------------------------------------------------------------------------
  function automatic logic signed [95:0] weighted(longint w, logic signed [CW-1:0] p);
    logic signed [95:0] wide_w, wide_p;
    wide_w = 96'(w);
    wide_p = 96'(p);  // sign-extends
    return wide_w * wide_p;
  endfunction

  function automatic logic [CW-1:0] bernstein_point(bit cubic, longint t,
      logic signed [CW-1:0] p0, logic signed [CW-1:0] p1,
      logic signed [CW-1:0] p2, logic signed [CW-1:0] p3);
    longint             u;
    int                 fr;
    logic signed [95:0] acc;
    u = T_ONE - t;
    if (cubic) begin
      acc = weighted(u * u * u, p0) + weighted(3 * u * u * t, p1)
          + weighted(3 * u * t * t, p2) + weighted(t * t * t, p3);
      fr  = 3 * TF;
    end else begin
      // second control point plays no part in a quadratic
      acc = weighted(u * u, p0) + weighted(2 * u * t, p1) + weighted(t * t, p3);
      fr  = 2 * TF;
    end
    acc = (acc + (96'sd1 <<< (fr - 1))) >>> fr;
    return acc[CW-1:0];
  endfunction

  // Queue every point one curve produces: N evaluated points, then the end point
  function automatic void flatten_curve(curve_t c);
    int     n;
    longint t;
    point_t p;
    n = (c.segs == 0) ? 1 : ((c.segs > MAXSEG) ? MAXSEG : int'(c.segs));
    for (int i = 0; i < n; i++) begin
      t      = (2 * longint'(i) * T_ONE + n) / (2 * n);
      p.x    = bernstein_point(c.func, t, c.sx, c.ax, c.bx, c.ex);
      p.y    = bernstein_point(c.func, t, c.sy, c.ay, c.by, c.ey);
      p.last = 1'b0;
      pending_points.push_back(p);
    end
    p.x    = c.ex;
    p.y    = c.ey;
    p.last = 1'b1;
    pending_points.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic curve_t mk_curve(bit f, logic [CW-1:0] sx, logic [CW-1:0] sy,
      logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] bx, logic [CW-1:0] by,
      logic [CW-1:0] ex, logic [CW-1:0] ey, logic [SEGW-1:0] segs);
    curve_t c;
    c.func = f;
    c.sx = sx; c.sy = sy; c.ax = ax; c.ay = ay;
    c.bx = bx; c.by = by; c.ex = ex; c.ey = ey;
    c.segs = segs;
    return c;
  endfunction

  // Mostly full-range, with extremes and small values mixed in
  function automatic logic [CW-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return MAX_COORD;
      1:       return MIN_COORD;
      2, 3:    return {{(CW-10){r[9]}}, r[9:0]};
      default: return r[CW-1:0];
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.func = 1'($urandom_range(1));
    c.sx = rand_coord(); c.sy = rand_coord();
    c.ax = rand_coord(); c.ay = rand_coord();
    c.bx = rand_coord(); c.by = rand_coord();
    c.ex = rand_coord(); c.ey = rand_coord();
    // lean on short curves so the run stays quick; full-length ones still show up
    case ($urandom_range(7))
      0, 1:    c.segs = SEGW'($urandom_range(4));
      2:       c.segs = SEGW'(MAXSEG);
      default: c.segs = SEGW'($urandom_range((1 << SEGW) - 1));
    endcase
    return c;
  endfunction

  // One transfer on the input side. Valid stays high on return so a
  // back-to-back curve never sees valid dropped and raised in one step.
  task automatic send_curve(curve_t c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= c.func;
    start_x  <= c.sx;  start_y  <= c.sy;
    ctrl_a_x <= c.ax;  ctrl_a_y <= c.ay;
    ctrl_b_x <= c.bx;  ctrl_b_y <= c.by;
    end_x    <= c.ex;  end_y    <= c.ey;
    segments <= c.segs;
    do @(posedge clk); while (in_stall);
    flatten_curve(c);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) send_curve(random_curve());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of every field, both degrees, zero segments, full segment count,
  // ignored second control on quadratics, alternating bit patterns.
  task automatic test_corner_curves();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_curve(mk_curve(FUNC_QUAD, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(mk_curve(FUNC_CUBIC, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(mk_curve(FUNC_QUAD, MIN_COORD, MIN_COORD, '0, '0, '0, '0,
                        MAX_COORD, MAX_COORD, SEGW'(1)));
    send_curve(mk_curve(FUNC_CUBIC, MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD,
                        MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD, SEGW'(MAXSEG)));
    send_curve(mk_curve(FUNC_QUAD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD,
                        MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, SEGW'(MAXSEG)));
    send_curve(mk_curve(FUNC_CUBIC, MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD,
                        MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD, SEGW'(MAXSEG)));
    // quadratic with a wild second control: must not leak into the points
    send_curve(mk_curve(FUNC_QUAD, '0, '0, MAX_COORD, MIN_COORD, MIN_COORD,
                        MAX_COORD, '0, '0, SEGW'(2)));
    send_curve(mk_curve(FUNC_CUBIC, MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD,
                        MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD, SEGW'(3)));
    // tiny coordinates, where rounding ties show up
    send_curve(mk_curve(FUNC_QUAD, '1, 24'd1, 24'd1, '1, '0, '0, '1, 24'd1, SEGW'(5)));
    send_curve(mk_curve(FUNC_CUBIC, 24'd1, '1, '0, 24'd1, '0, '1, '0, '0, SEGW'(7)));
    send_curve(mk_curve(FUNC_QUAD, ODD_BITS, EVEN_BITS, EVEN_BITS, ODD_BITS,
                        ODD_BITS, EVEN_BITS, EVEN_BITS, ODD_BITS, 6'b101010));
    send_curve(mk_curve(FUNC_CUBIC, EVEN_BITS, ODD_BITS, ODD_BITS, EVEN_BITS,
                        EVEN_BITS, ODD_BITS, ODD_BITS, EVEN_BITS, 6'b010101));
    send_curve(mk_curve(FUNC_CUBIC, MAX_COORD, MAX_COORD, '0, '0, '0, '0,
                        MIN_COORD, MIN_COORD, SEGW'(4)));
  endtask

  task automatic test_slow_receiver();
    in_idle_pct  = 13;
    out_idle_pct = 58;
    run_random(150);
  endtask

  task automatic test_slow_sender();
    in_idle_pct  = 58;
    out_idle_pct = 13;
    run_random(150);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the input side stalls.
  task automatic test_output_hold();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_reqs   <= hold_reqs + 1;
    run_random(4);
  endtask

  // Sender goes quiet until every expected point has come back.
  task automatic test_drain_pause();
    in_idle_pct  = 13;
    out_idle_pct = 13;
    repeat (3) begin
      run_random(2);
      idle_input();
      wait_for_drain();
    end
  endtask

  task automatic test_full_rate();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(135);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    func     = FUNC_QUAD;
    start_x  = '0;  start_y  = '0;
    ctrl_a_x = '0;  ctrl_a_y = '0;
    ctrl_b_x = '0;  ctrl_b_y = '0;
    end_x    = '0;  end_y    = '0;
    segments = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_corner_curves();
    test_slow_receiver();
    test_slow_sender();
    test_output_hold();
    test_drain_pause();
    test_full_rate();

    idle_input();
    wait_for_drain();
    // late or extra points would land here and be flagged by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Point checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, got x=%h y=%h last=%b",
                 $time, point_x, point_y, last);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $display("%0t: point_x expected %h got %h", $time, want.x, point_x);
          mismatches++;
        end
        if (point_y !== want.y) begin
          $display("%0t: point_y expected %h got %h", $time, want.y, point_y);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a transfer on either side means a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== bezier_curve_flattener.f =====
hw/rtl/bcf_pkg.sv
hw/rtl/bcf_datapath.sv
hw/rtl/bcf_ctrl.sv
hw/rtl/bezier_curve_flattener.sv
hw/rtl/bcf_checker.sv
tb/sv/tb.sv
